FILE: sv/ubxpc_pkg.sv
// ubxpc_pkg: constants, types and helpers for the ubx posllh frame checker
// no dependencies, imported by every module of the block

package ubxpc_pkg;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CAPTURE_FIRST   = 2;
    localparam int CAPTURE_COUNT   = 32;
    localparam int CAP_IDX_W       = $clog2(CAPTURE_COUNT);
    localparam int CAPTURE_LAST    = CAPTURE_FIRST + CAPTURE_COUNT - 1;
    localparam int MIN_FRAME_LAST  = 3;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CAPTURE_COUNT-1:0][7:0] t_cap_bytes;

    typedef struct packed {
        logic checksum_ok;
        t_pos pos;
    } t_track;

    typedef struct packed {
        logic               checksum_ok;
        logic        [7:0]  msg_class;
        logic        [7:0]  msg_id;
        logic        [15:0] payload_length;
        logic        [31:0] time_of_week_ms;
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic signed [31:0] height_ellipsoid;
        logic signed [31:0] height_sea_level;
        logic        [31:0] horizontal_accuracy;
        logic        [31:0] vertical_accuracy;
    } t_result;

    // little-endian 32-bit word from captured bytes at frame index idx
    function automatic logic [31:0] word32(t_cap_bytes cap, int idx);
        word32 = {cap[idx - CAPTURE_FIRST + 3], cap[idx - CAPTURE_FIRST + 2],
                  cap[idx - CAPTURE_FIRST + 1], cap[idx - CAPTURE_FIRST]};
    endfunction

endpackage

FILE: sv/ubxpc_if.sv
// ubxpc_if: valid/ready channels for frame bytes and decoded results
// depends on no other file

interface ubxpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ubxpc_result_if;
    logic               valid;
    logic               ready;
    logic               checksum_ok;
    logic        [7:0]  msg_class;
    logic        [7:0]  msg_id;
    logic        [15:0] payload_length;
    logic        [31:0] time_of_week_ms;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] height_ellipsoid;
    logic signed [31:0] height_sea_level;
    logic        [31:0] horizontal_accuracy;
    logic        [31:0] vertical_accuracy;

    modport source (
        output valid, input ready, output checksum_ok, output msg_class, output msg_id,
        output payload_length, output time_of_week_ms, output longitude, output latitude,
        output height_ellipsoid, output height_sea_level, output horizontal_accuracy,
        output vertical_accuracy
    );
    modport sink (
        input valid, output ready, input checksum_ok, input msg_class, input msg_id,
        input payload_length, input time_of_week_ms, input longitude, input latitude,
        input height_ellipsoid, input height_sea_level, input horizontal_accuracy,
        input vertical_accuracy
    );
endinterface

FILE: sv/ubxpc_track.sv
// ubxpc_track: byte position, running fletcher sums and checksum compare
// depends on ubxpc_pkg

module ubxpc_track
    import ubxpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_frame_byte,
    input  logic       i_frame_last,
    output t_track     o_track
);

    t_pos        r_pos,       n_pos;
    logic [7:0]  r_sum_a,     n_sum_a;
    logic [7:0]  r_sum_b,     n_sum_b;
    logic [15:0] r_hist,      n_hist;
    logic [7:0]  r_prev_byte, n_prev_byte;
    logic [7:0]  sum_a_add;

    assign sum_a_add = r_sum_a + i_frame_byte;

    always_comb begin
        n_pos       = r_pos;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_hist      = r_hist;
        n_prev_byte = r_prev_byte;
        if (i_take) begin
            n_prev_byte = i_frame_byte;
            if (i_frame_last) begin
                n_pos   = '0;
                n_sum_a = '0;
                n_sum_b = '0;
                n_hist  = '0;
            end else begin
                n_hist = {r_sum_a, r_sum_b};
                if (r_pos >= t_pos'(CAPTURE_FIRST)) begin
                    n_sum_a = sum_a_add;
                    n_sum_b = r_sum_b + sum_a_add;
                end
                if (r_pos != t_pos'(MAX_FRAME_BYTES)) begin
                    n_pos = r_pos + t_pos'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_hist      <= '0;
            r_prev_byte <= '0;
        end else begin
            r_pos       <= n_pos;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_hist      <= n_hist;
            r_prev_byte <= n_prev_byte;
        end
    end

    // sums before the second-to-last byte against the two trailing bytes
    assign o_track.checksum_ok = (r_pos >= t_pos'(MIN_FRAME_LAST)) &&
                                 (r_hist == {r_prev_byte, i_frame_byte});
    assign o_track.pos         = r_pos;

endmodule

FILE: sv/ubxpc_capture.sv
// ubxpc_capture: holds frame bytes 2 to 33, masks bytes not yet received
// depends on ubxpc_pkg

module ubxpc_capture
    import ubxpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_take,
    input  t_pos       i_pos,
    input  logic [7:0] i_frame_byte,
    output t_cap_bytes o_bytes
);

    t_cap_bytes         r_cap;
    logic               in_window;
    logic [CAP_IDX_W-1:0] wr_idx;
    t_pos               rel_pos;

    assign in_window = (i_pos >= t_pos'(CAPTURE_FIRST)) && (i_pos <= t_pos'(CAPTURE_LAST));
    assign rel_pos   = i_pos - t_pos'(CAPTURE_FIRST);
    assign wr_idx    = rel_pos[CAP_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_take && in_window) begin
            r_cap[wr_idx] <= i_frame_byte;
        end
    end

    // current byte bypasses its slot, slots beyond the current byte read zero
    always_comb begin
        for (int c = 0; c < CAPTURE_COUNT; c++) begin
            if (in_window && (wr_idx == CAP_IDX_W'(c))) begin
                o_bytes[c] = i_frame_byte;
            end else if ({1'b0, i_pos} >= (POS_W + 1)'(c + CAPTURE_FIRST)) begin
                o_bytes[c] = r_cap[c];
            end else begin
                o_bytes[c] = '0;
            end
        end
    end

endmodule

FILE: sv/ubxpc_out_reg.sv
// ubxpc_out_reg: decodes header and payload words into the result register
// depends on ubxpc_pkg and ubxpc_result_if

module ubxpc_out_reg
    import ubxpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_track     i_track,
    input  t_cap_bytes i_bytes,
    output logic       o_can_load,
    ubxpc_result_if.source o_result
);

    logic    r_valid, n_valid;
    t_result r_result, n_result;

    always_comb begin
        n_result.checksum_ok         = i_track.checksum_ok;
        n_result.msg_class           = i_bytes[0];
        n_result.msg_id              = i_bytes[1];
        n_result.payload_length      = {i_bytes[3], i_bytes[2]};
        n_result.time_of_week_ms     = word32(i_bytes, 6);
        n_result.longitude           = word32(i_bytes, 10);
        n_result.latitude            = word32(i_bytes, 14);
        n_result.height_ellipsoid    = word32(i_bytes, 18);
        n_result.height_sea_level    = word32(i_bytes, 22);
        n_result.horizontal_accuracy = word32(i_bytes, 26);
        n_result.vertical_accuracy   = word32(i_bytes, 30);
    end

    assign o_can_load = !r_valid || o_result.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid               = r_valid;
    assign o_result.checksum_ok         = r_result.checksum_ok;
    assign o_result.msg_class           = r_result.msg_class;
    assign o_result.msg_id              = r_result.msg_id;
    assign o_result.payload_length      = r_result.payload_length;
    assign o_result.time_of_week_ms     = r_result.time_of_week_ms;
    assign o_result.longitude           = r_result.longitude;
    assign o_result.latitude            = r_result.latitude;
    assign o_result.height_ellipsoid    = r_result.height_ellipsoid;
    assign o_result.height_sea_level    = r_result.height_sea_level;
    assign o_result.horizontal_accuracy = r_result.horizontal_accuracy;
    assign o_result.vertical_accuracy   = r_result.vertical_accuracy;

endmodule

FILE: sv/ubx_posllh_frame_checker_core.sv
// ubx_posllh_frame_checker_core: ubx nav-posllh frame checker top level
// depends on ubxpc_pkg, ubxpc_if, ubxpc_track, ubxpc_capture, ubxpc_out_reg
//
//   channel    dir   word
//   i_byte     in    frame_byte, frame_last
//   o_result   out   checksum_ok, msg_class .. vertical_accuracy
//
// one byte per cycle while i_byte.ready is high; the result of a frame is registered and appears
// in the cycle after its last byte is taken; state is updated in the cycle a byte is taken,
// the result register sits after it; i_byte.ready drops only while a result is held and o_result.ready is low
// synchronous active-low reset clears position, sums and result valid

module ubx_posllh_frame_checker_core
    import ubxpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ubxpc_byte_if.sink     i_byte,
    ubxpc_result_if.source o_result
);

    logic       can_load;
    logic       take;
    t_track     track;
    t_cap_bytes cap_bytes;

    assign i_byte.ready = can_load;
    assign take         = i_byte.valid && can_load;

    ubxpc_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_frame_byte (i_byte.frame_byte),
        .i_frame_last (i_byte.frame_last),
        .o_track      (track)
    );

    ubxpc_capture u_capture (
        .i_clk        (i_clk),
        .i_take       (take),
        .i_pos        (track.pos),
        .i_frame_byte (i_byte.frame_byte),
        .o_bytes      (cap_bytes)
    );

    ubxpc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && i_byte.frame_last),
        .i_track    (track),
        .i_bytes    (cap_bytes),
        .o_can_load (can_load),
        .o_result   (o_result)
    );

endmodule

FILE: tb/sv/ubx_posllh_frame_checker_core_tb.sv
`timescale 1ns / 100ps
// ubx_posllh_frame_checker_core_tb: self-checking bench for the ubx nav-posllh frame checker
// feeds frame bytes with random gaps and stalls, checks each report against a built-in decoder
// or a fixed directed row; depends on ubxpc_pkg, ubxpc_if and ubx_posllh_frame_checker_core

module ubx_posllh_frame_checker_core_tb;
    import ubxpc_pkg::*;

    localparam int N_DIRECTED        = 22;
    localparam int DIRECTED_FRAMES   = 6;
    localparam int RANDOM_BYTES      = 1000;
    localparam int MIN_RANDOM_FRAMES = 16;
    localparam int LONG_FRAME_BYTES  = 300;
    localparam int LONG_FRAME_AFTER  = 350;
    localparam int HOLD_OFF_AT       = 12;
    localparam int HOLD_OFF_CYCLES   = 400;
    localparam int MAX_GAP           = 13;
    localparam int DRAIN_CYCLES      = 8;
    localparam int POSLLH_PAYLOAD    = 28;

    localparam logic [7:0] SYNC_1     = 8'hB5;
    localparam logic [7:0] SYNC_2     = 8'h62;
    localparam logic [7:0] CLASS_NAV  = 8'h01;
    localparam logic [7:0] ID_POSLLH  = 8'h02;

    typedef struct packed {
        logic [7:0]  fbyte;
        logic        last;
        logic        fixed;
        logic        ok;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] plen;
    } t_dir_row;

    // rows with fixed set carry their report, the rest go through the decoder
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hB5, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h62, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 8'h00, 16'h0000},
        '{8'hB5, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h62, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 16'h0000},
        '{8'hB5, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h62, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h03, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h04, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'hB5, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h62, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h02, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h03, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000},
        '{8'h05, 1'b1, 1'b1, 1'b0, 8'h01, 8'h02, 16'h0503}
    };

    logic i_clk;
    logic i_rst_n;

    ubxpc_byte_if   byte_ch ();
    ubxpc_result_if rpt_ch ();

    ubx_posllh_frame_checker_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (rpt_ch)
    );

    // decoder state
    int unsigned fr_pos;
    logic [7:0]  fl_a;
    logic [7:0]  fl_b;
    logic [15:0] sums_before [2];
    logic [7:0]  tail_bytes [2];
    logic [7:0]  frame_cap [CAPTURE_COUNT];

    t_result     pending_reports [$];
    logic [7:0]  frame_buf [$];

    int          bytes_sent;
    int          frames_sent;
    int          reports_checked;
    int          good_reports;
    int          error_count;
    bit          src_steady;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic clear_decoder();
        fr_pos = 0;
        fl_a = '0;
        fl_b = '0;
        sums_before[0] = '0;
        sums_before[1] = '0;
        for (int k = 0; k < CAPTURE_COUNT; k++) frame_cap[k] = '0;
    endtask

    function automatic logic [31:0] cap_le32(int idx);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++) w[8*k +: 8] = frame_cap[idx - CAPTURE_FIRST + k];
        return w;
    endfunction

    task automatic decode_frame_byte(input logic [7:0] b, input logic last,
                                     output logic has_report, output t_result rpt);
        int unsigned pos;
        pos = fr_pos;
        has_report = 1'b0;
        rpt = '0;
        sums_before[1] = sums_before[0];
        sums_before[0] = {fl_a, fl_b};
        tail_bytes[0] = tail_bytes[1];
        tail_bytes[1] = b;
        if (pos >= CAPTURE_FIRST) begin
            fl_a = fl_a + b;
            fl_b = fl_b + fl_a;
            if (pos <= CAPTURE_LAST) frame_cap[pos - CAPTURE_FIRST] = b;
        end
        if (pos < MAX_FRAME_BYTES) fr_pos = pos + 1;
        if (last) begin
            has_report = 1'b1;
            rpt.checksum_ok = (pos >= MIN_FRAME_LAST) &&
                              (sums_before[1] == {tail_bytes[0], tail_bytes[1]});
            rpt.msg_class           = frame_cap[0];
            rpt.msg_id              = frame_cap[1];
            rpt.payload_length      = {frame_cap[3], frame_cap[2]};
            rpt.time_of_week_ms     = cap_le32(6);
            rpt.longitude           = cap_le32(10);
            rpt.latitude            = cap_le32(14);
            rpt.height_ellipsoid    = cap_le32(18);
            rpt.height_sea_level    = cap_le32(22);
            rpt.horizontal_accuracy = cap_le32(26);
            rpt.vertical_accuracy   = cap_le32(30);
            clear_decoder();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_report(input t_result got);
        t_result want;
        if (pending_reports.size() == 0) begin
            error_count++;
            $display("%0t: report with none expected, expected nothing, actual %h", $time, got);
        end else begin
            want = pending_reports.pop_front();
            check_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
            check_field("msg_class", 32'(want.msg_class), 32'(got.msg_class));
            check_field("msg_id", 32'(want.msg_id), 32'(got.msg_id));
            check_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
            check_field("time_of_week_ms", want.time_of_week_ms, got.time_of_week_ms);
            check_field("longitude", want.longitude, got.longitude);
            check_field("latitude", want.latitude, got.latitude);
            check_field("height_ellipsoid", want.height_ellipsoid, got.height_ellipsoid);
            check_field("height_sea_level", want.height_sea_level, got.height_sea_level);
            check_field("horizontal_accuracy", want.horizontal_accuracy,
                        got.horizontal_accuracy);
            check_field("vertical_accuracy", want.vertical_accuracy, got.vertical_accuracy);
            reports_checked++;
            if (got.checksum_ok) good_reports++;
        end
    endtask

    // called at a rising edge, returns at the edge where the byte is taken
    task automatic offer_byte(input logic [7:0] b, input logic last,
                              input logic use_fixed, input t_result fixed_rpt);
        int      gap;
        logic    has;
        t_result rpt;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.frame_byte <= b;
        byte_ch.frame_last <= last;
        do @(negedge i_clk); while (!byte_ch.ready);
        @(posedge i_clk);
        decode_frame_byte(b, last, has, rpt);
        if (has) pending_reports.push_back(use_fixed ? fixed_rpt : rpt);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            offer_byte(frame_buf[i], i == frame_buf.size() - 1, 1'b0, '0);
        frames_sent++;
    endtask

    task automatic append_checksum();
        logic [7:0] a;
        logic [7:0] s;
        a = '0;
        s = '0;
        for (int i = 2; i < frame_buf.size(); i++) begin
            a = a + frame_buf[i];
            s = s + a;
        end
        frame_buf.push_back(a);
        frame_buf.push_back(s);
    endtask

    task automatic build_posllh_frame();
        int fill;
        fill = $urandom_range(0, 9);
        frame_buf = {SYNC_1, SYNC_2, CLASS_NAV, ID_POSLLH, 8'(POSLLH_PAYLOAD), 8'h00};
        for (int i = 0; i < POSLLH_PAYLOAD; i++)
            frame_buf.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom));
        append_checksum();
        // broken frame: one flipped bit somewhere after the sync bytes
        if ($urandom_range(0, 3) == 0)
            frame_buf[$urandom_range(2, frame_buf.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    endtask

    task automatic build_sized_frame(input int len, input bit noise);
        frame_buf = {};
        if (noise) begin
            for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
        end else begin
            frame_buf = {SYNC_1, SYNC_2};
            for (int i = 0; i < len - 4; i++) frame_buf.push_back(8'($urandom));
            append_checksum();
        end
    endtask

    // result side
    initial begin
        int      stall;
        int      seen;
        bit      steady;
        t_result got;
        seen = 0;
        steady = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) steady = ~steady;
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
            if (stall > 0) begin
                rpt_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rpt_ch.ready <= 1'b1;
            do @(negedge i_clk); while (!rpt_ch.valid);
            got.checksum_ok         = rpt_ch.checksum_ok;
            got.msg_class           = rpt_ch.msg_class;
            got.msg_id              = rpt_ch.msg_id;
            got.payload_length      = rpt_ch.payload_length;
            got.time_of_week_ms     = rpt_ch.time_of_week_ms;
            got.longitude           = rpt_ch.longitude;
            got.latitude            = rpt_ch.latitude;
            got.height_ellipsoid    = rpt_ch.height_ellipsoid;
            got.height_sea_level    = rpt_ch.height_sea_level;
            got.horizontal_accuracy = rpt_ch.horizontal_accuracy;
            got.vertical_accuracy   = rpt_ch.vertical_accuracy;
            check_report(got);
            seen++;
            @(posedge i_clk);
        end
    end

    // byte side
    initial begin
        t_result fixed_rpt;
        int      kind;
        bit      long_sent;
        byte_ch.valid      <= 1'b0;
        byte_ch.frame_byte <= '0;
        byte_ch.frame_last <= 1'b0;
        rpt_ch.ready       <= 1'b0;
        i_rst_n            <= 1'b0;
        bytes_sent = 0;
        frames_sent = 0;
        reports_checked = 0;
        good_reports = 0;
        error_count = 0;
        src_steady = 1'b0;
        long_sent = 1'b0;
        clear_decoder();
        tail_bytes[0] = '0;
        tail_bytes[1] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            fixed_rpt = '0;
            fixed_rpt.checksum_ok    = DIRECTED[i].ok;
            fixed_rpt.msg_class      = DIRECTED[i].cls;
            fixed_rpt.msg_id         = DIRECTED[i].id;
            fixed_rpt.payload_length = DIRECTED[i].plen;
            offer_byte(DIRECTED[i].fbyte, DIRECTED[i].last, DIRECTED[i].fixed, fixed_rpt);
        end

        while (bytes_sent < N_DIRECTED + RANDOM_BYTES || frames_sent < MIN_RANDOM_FRAMES) begin
            src_steady = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (!long_sent && bytes_sent > LONG_FRAME_AFTER) begin
                // position counter saturates, sums keep running
                build_sized_frame(LONG_FRAME_BYTES, 1'b0);
                long_sent = 1'b1;
            end else if (kind < 60) begin
                build_posllh_frame();
            end else if (kind < 85) begin
                build_sized_frame($urandom_range(4, 40), 1'b0);
            end else begin
                build_sized_frame($urandom_range(1, 40), 1'b1);
            end
            send_frame();
        end
        byte_ch.valid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d frame bytes in %0d frames (one long frame, one long result stall)",
                 bytes_sent, frames_sent + DIRECTED_FRAMES);
        $display("%0d reports checked, %0d with a good checksum, %0d mismatches",
                 reports_checked, good_reports, error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
